### rtl/core/lmtf_pkg.sv
// Package for the move-to-front LRU cache directory.
// Holds the fixed payload widths shared by the channel interfaces and the top level.
// No dependencies.
package lmtf_pkg;

    // Payload widths of the lookup and result transactions
    localparam int LOOKUP_KEY_W = 64;
    localparam int SLOT_W       = 5;

    typedef logic [LOOKUP_KEY_W-1:0] lookup_key_t;
    typedef logic [SLOT_W-1:0]       slot_t;

endpackage

### rtl/core/lmtf_in_if.sv
// Lookup channel: valid/ready handshake carrying one key per transaction.
// Depends on lmtf_pkg for the key width.
interface lmtf_in_if;
    import lmtf_pkg::*;

    logic        valid;
    logic        ready;
    lookup_key_t lookup_key;

    modport source (output valid, output lookup_key, input ready);
    modport sink   (input valid, input lookup_key, output ready);
endinterface

### rtl/core/lmtf_out_if.sv
// Result channel: valid/ready handshake carrying one lookup result per transaction.
// Depends on lmtf_pkg for the slot and key widths.
interface lmtf_out_if;
    import lmtf_pkg::*;

    logic        valid;
    logic        ready;
    logic        hit;
    slot_t       slot;
    logic        evicted;
    lookup_key_t evicted_key;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_key, output ready);
endinterface

### rtl/core/lmtf_cell.sv
// One rank of the recency list: holds key, valid flag and storage slot.
// Compares its key against the lookup key and loads from its left neighbour on shift.
// No package dependencies.
module lmtf_cell #(
    parameter int KEY_BITS   = 64,
    parameter int SLOT_BITS  = 5,
    parameter int RESET_SLOT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  logic [KEY_BITS-1:0]  probe_key,
    input  logic [KEY_BITS-1:0]  prev_key,
    input  logic                 prev_valid,
    input  logic [SLOT_BITS-1:0] prev_slot,
    output logic                 match,
    output logic [KEY_BITS-1:0]  key,
    output logic                 valid,
    output logic [SLOT_BITS-1:0] slot
);

    logic [KEY_BITS-1:0]  key_reg;
    logic                 valid_reg;
    logic [SLOT_BITS-1:0] slot_reg;

    // Hold the key payload; take the neighbour's on shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg <= prev_key;
        end
    end

    // Valid and slot come out of reset as empty rank owning its own slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= SLOT_BITS'(RESET_SLOT);
        end
        else if (shift_en)
        begin
            valid_reg <= prev_valid;
            slot_reg  <= prev_slot;
        end
    end

    // Empty ranks never match
    assign match = valid_reg && (key_reg == probe_key);
    assign key   = key_reg;
    assign valid = valid_reg;
    assign slot  = slot_reg;

endmodule

### rtl/core/lru_move_to_front_cache.sv
// Fully associative cache directory with true LRU order, kept as a row of rank cells
// (rank 0 most recent). Lookup channel "lookup" carries one key per transaction;
// result channel "result" returns hit, slot, evicted and evicted_key for each lookup.
// A hit moves the entry to rank 0 and reports its slot. A miss inserts the key at
// rank 0, taking the slot of the last rank; if that rank was occupied its key is
// reported as evicted (evicted_key is zero otherwise).
// Latency: an accepted key is held in the pending-lookup register, compared against all
// ranks, and its result is loaded into the result register when it commits, which can
// wait while the result register is full and result.ready is low. Throughput: one lookup
// per cycle while the result channel does not stall, set by the parallel compare and
// one-position shift of the cell row.
// Reset: all ranks empty, rank r owns slot r; no result pending.
// Stall: while the result register is full and result.ready is low, the pending
// lookup waits in its register and lookup.ready drops; nothing is lost.
// Depends on lmtf_pkg, lmtf_in_if, lmtf_out_if and lmtf_cell.
module lru_move_to_front_cache #(
    parameter int ENTRIES  = 20,
    parameter int KEY_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    lmtf_in_if.sink    lookup,
    lmtf_out_if.source result
);
    import lmtf_pkg::*;

    localparam int SB = $clog2(ENTRIES);

    logic                busy_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                commit;

    logic [ENTRIES-1:0]  match;
    logic [ENTRIES-1:0]  shift_en;
    logic [KEY_BITS-1:0] cell_key   [ENTRIES];
    logic                cell_valid [ENTRIES];
    logic [SB-1:0]       cell_slot  [ENTRIES];

    logic                any_hit;
    logic [SB-1:0]       hit_slot;
    logic [SB-1:0]       front_slot;
    logic                evict;

    logic                out_valid_reg;
    logic                hit_reg;
    slot_t               slot_reg;
    logic                evicted_reg;
    lookup_key_t         evicted_key_reg;

    // Resolve the pending lookup when the result register can take it
    assign commit       = busy_reg && (!out_valid_reg || result.ready);
    assign lookup.ready = !busy_reg || commit;

    // Hold the pending lookup key
    always_ff @(posedge clk)
    begin
        if (lookup.valid && lookup.ready)
        begin
            key_reg <= lookup.lookup_key[KEY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (lookup.ready)
        begin
            busy_reg <= lookup.valid;
        end
    end

    // Pick the slot of the matching rank (at most one rank matches)
    assign any_hit = |match;

    always_comb
    begin
        hit_slot = '0;
        for (int r = 0; r < ENTRIES; r++)
        begin
            if (match[r])
            begin
                hit_slot = hit_slot | cell_slot[r];
            end
        end
    end

    assign front_slot = any_hit ? hit_slot : cell_slot[ENTRIES-1];
    assign evict      = !any_hit && cell_valid[ENTRIES-1];

    // Shift every rank from rank 0 up to the matching one; all ranks on a miss
    generate
        for (genvar r = 0; r < ENTRIES; r++)
        begin : g_shift
            assign shift_en[r] = commit && (!any_hit || ((match >> r) != '0));
        end
    endgenerate

    // Row of rank cells; rank 0 takes the lookup key
    generate
        for (genvar r = 0; r < ENTRIES; r++)
        begin : g_cell
            if (r == 0)
            begin : g_front
                lmtf_cell #(
                    .KEY_BITS   (KEY_BITS),
                    .SLOT_BITS  (SB),
                    .RESET_SLOT (r)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift_en   (shift_en[r]),
                    .probe_key  (key_reg),
                    .prev_key   (key_reg),
                    .prev_valid (1'b1),
                    .prev_slot  (front_slot),
                    .match      (match[r]),
                    .key        (cell_key[r]),
                    .valid      (cell_valid[r]),
                    .slot       (cell_slot[r])
                );
            end
            else
            begin : g_rest
                lmtf_cell #(
                    .KEY_BITS   (KEY_BITS),
                    .SLOT_BITS  (SB),
                    .RESET_SLOT (r)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift_en   (shift_en[r]),
                    .probe_key  (key_reg),
                    .prev_key   (cell_key[r-1]),
                    .prev_valid (cell_valid[r-1]),
                    .prev_slot  (cell_slot[r-1]),
                    .match      (match[r]),
                    .key        (cell_key[r]),
                    .valid      (cell_valid[r]),
                    .slot       (cell_slot[r])
                );
            end
        end
    endgenerate

    // Result payload: load on commit
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            hit_reg         <= any_hit;
            slot_reg        <= SLOT_W'(front_slot);
            evicted_reg     <= evict;
            evicted_key_reg <= evict ? LOOKUP_KEY_W'(cell_key[ENTRIES-1]) : '0;
        end
    end

    // Result valid: set on commit, drop once the transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.hit         = hit_reg;
    assign result.slot        = slot_reg;
    assign result.evicted     = evicted_reg;
    assign result.evicted_key = evicted_key_reg;

endmodule
